FILE: src/ascending_integer_sorter_core_defines.svh
// Assertion macros for the sorter checker.
`ifndef ASCENDING_INTEGER_SORTER_CORE_DEFINES_SVH
`define ASCENDING_INTEGER_SORTER_CORE_DEFINES_SVH

// Clocked assertion with reset disable; prop is a full property expression.
`define ASC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Next-cycle implication form.
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/asc_pkg.sv
// Types shared by the sorter core, its cells and its checker.
package asc_pkg;

   localparam int unsigned DataWidth = 32;

   // Input beat
   typedef struct packed {
      logic signed [DataWidth-1:0] value;
      logic                        last;
   } req_type;

   // Result beat
   typedef struct packed {
      logic signed [DataWidth-1:0] sorted_value;
      logic                        final_res;
      logic                        dropped;
   } rsp_type;

   // What one cell shows its neighbors
   typedef struct packed {
      logic                        valid;
      logic                        gt;
      logic signed [DataWidth-1:0] value;
   } cell_type;

   // Row-wide control broadcast to every cell
   typedef struct packed {
      logic                        ins;
      logic                        drain;
      logic signed [DataWidth-1:0] key;
   } ctl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } st_type;

endpackage

FILE: src/asc_cell.sv
// One sorting cell: holds one element, inserts from the left, drains from the right.
module asc_cell (
   input  logic              clock,
   input  logic              reset,
   input  asc_pkg::ctl_type  ctl,
   input  asc_pkg::cell_type left_cell,
   input  asc_pkg::cell_type right_cell,
   output asc_pkg::cell_type cell_out
);
   import asc_pkg::*;

   logic                        valid_ff, valid_in;
   logic signed [DataWidth-1:0] value_ff, value_in;
   logic                        gt;

   // New key belongs at or before this cell
   assign gt = !valid_ff || (ctl.key < value_ff);

   assign cell_out.valid = valid_ff;
   assign cell_out.gt    = gt;
   assign cell_out.value = value_ff;

   // Insert: shift right behind the key's slot; drain: shift left
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.ins) begin
         if (gt && left_cell.gt) begin
            valid_in = left_cell.valid;
            value_in = left_cell.value;
         end else if (gt) begin
            valid_in = 1'b1;
            value_in = ctl.key;
         end
      end else if (ctl.drain) begin
         valid_in = right_cell.valid;
         value_in = right_cell.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: src/ascending_integer_sorter_core.sv
// Top level of the ascending sorter: a row of insertion cells plus load/drain control.
//
//   channel | ports                       | handshake
//   input   | start, busy, req_data       | beat taken when start && !busy
//   result  | rsp_strobe, rsp_data        | one-cycle strobe, cannot be held off
//
// Loading takes one element per cycle; each element that finds room is placed in its
// slot in the cell row in the cycle it is accepted, and a beat that finds the row full
// is dropped. After the beat marked last, the row drains one element per cycle from
// cell 0; busy stays high until the final result. Reset is synchronous and empties the row.
module ascending_integer_sorter_core #(
   parameter int unsigned MAX_ELEMS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  asc_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output asc_pkg::rsp_type rsp_data
);
   import asc_pkg::*;

   st_type   state_ff, state_in;
   logic     ovf_ff, ovf_in;
   logic     accept, full, final_beat;
   ctl_type  ctl;
   cell_type cells [MAX_ELEMS];

   assign accept     = start && !busy;
   assign full       = cells[MAX_ELEMS-1].valid;
   assign final_beat = (state_ff == ST_DRAIN) && !cells[1].valid;

   assign ctl.ins   = accept && !full;
   assign ctl.drain = (state_ff == ST_DRAIN);
   assign ctl.key   = req_data.value;

   // Cell row
   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
      cell_type left_cell, right_cell;
      if (i == 0) begin : g_first
         assign left_cell = '0;
      end else begin : g_mid_l
         assign left_cell = cells[i-1];
      end
      if (i == MAX_ELEMS - 1) begin : g_last
         assign right_cell = '0;
      end else begin : g_mid_r
         assign right_cell = cells[i+1];
      end
      asc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_cell  (left_cell),
         .right_cell (right_cell),
         .cell_out   (cells[i])
      );
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:  if (accept && req_data.last) state_in = ST_DRAIN;
         ST_DRAIN: if (final_beat) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // Outputs
   always_comb begin
      busy                  = 1'b0;
      rsp_strobe            = 1'b0;
      rsp_data.sorted_value = cells[0].value;
      rsp_data.final_res    = final_beat;
      rsp_data.dropped      = ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
         end
         ST_DRAIN: begin
            busy       = 1'b1;
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // Overflow flag: set on a beat that finds the row full, cleared after the set drains
   always_comb begin
      ovf_in = ovf_ff;
      if (final_beat) begin
         ovf_in = 1'b0;
      end else if (accept && full) begin
         ovf_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

FILE: src/asc_checker.sv
// Port-level checks on the sorter core, bound to the top level.
`include "ascending_integer_sorter_core_defines.svh"

module asc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input asc_pkg::req_type req_data,
   input logic             busy,
   input logic             rsp_strobe,
   input asc_pkg::rsp_type rsp_data
);
   import asc_pkg::*;

   // A marked beat opens a drain in the next cycle
   `ASC_ASSERT_NEXT(a_last_starts_drain, start && !busy && req_data.last, rsp_strobe && busy, "marked beat did not start results")

   // Results come out in a burst until the final one
   `ASC_ASSERT_NEXT(a_burst_continues, rsp_strobe && !rsp_data.final_res, rsp_strobe, "gap inside result burst")

   // Block frees up right after the final result
   `ASC_ASSERT_NEXT(a_final_frees, rsp_strobe && rsp_data.final_res, !busy && !rsp_strobe, "busy after final result")

   // Results ascend within a set
   `ASC_ASSERT_NEXT(a_ascending, rsp_strobe && !rsp_data.final_res, rsp_data.sorted_value >= $past(rsp_data.sorted_value), "results out of order")

   // Drop flag is the same on every result of a set
   `ASC_ASSERT_NEXT(a_drop_steady, rsp_strobe && !rsp_data.final_res, $stable(rsp_data.dropped), "drop flag changed within set")

endmodule

bind ascending_integer_sorter_core asc_checker u_asc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .req_data   (req_data),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

FILE: dv/ascending_integer_sorter_core_tb.sv
// Self-checking testbench for the ascending sorter core: random sets against a queue-based predictor.
`timescale 1ns / 1ps

module ascending_integer_sorter_core_tb;
   import asc_pkg::*;

   localparam int unsigned SetCapacity = 32;
   localparam int unsigned RandomBeats = 480;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned DrainSlack  = SetCapacity + 8;

   localparam logic signed [DataWidth-1:0] MostNegative = 32'h8000_0000;
   localparam logic signed [DataWidth-1:0] MostPositive = 32'h7fff_ffff;

   // Value sources for one set
   typedef enum int {
      VAL_FULL,
      VAL_NARROW,
      VAL_EXTREME
   } value_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type                     pending_beats[$];
   logic signed [DataWidth-1:0] held_set[$];
   bit                          set_overflow = 1'b0;
   rsp_type                     expected_sorted[$];
   int                          accepted_beats = 0;
   int                          error_count = 0;
   int                          cycle_count = 0;
   bit                          beat_taken = 1'b0;
   int                          idle_pct;

   ascending_integer_sorter_core #(
      .MAX_ELEMS(SetCapacity)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor: insert each element in order, emit the whole set on the marked beat
   function automatic void absorb_element(req_type beat);
      int                          pos;
      logic signed [DataWidth-1:0] v;
      rsp_type                     r;
      v = beat.value;
      if (held_set.size() < SetCapacity) begin
         pos = 0;
         while (pos < held_set.size() && held_set[pos] <= v) pos++;
         held_set.insert(pos, v);
      end else begin
         set_overflow = 1'b1;
      end
      if (beat.last) begin
         foreach (held_set[k]) begin
            r.sorted_value = held_set[k];
            r.final_res    = (k == held_set.size() - 1);
            r.dropped      = set_overflow;
            expected_sorted.push_back(r);
         end
         held_set.delete();
         set_overflow = 1'b0;
      end
   endfunction

   function automatic logic signed [DataWidth-1:0] pick_value(value_mode_type mode);
      case (mode)
         VAL_FULL:   return $urandom;
         VAL_NARROW: return $urandom_range(0, 15) - 8;
         default: begin
            case ($urandom_range(0, 3))
               0:       return MostNegative;
               1:       return MostPositive;
               2:       return '0;
               default: return '1;
            endcase
         end
      endcase
   endfunction

   task automatic push_beat(input logic signed [DataWidth-1:0] v, input bit is_last);
      req_type b;
      b.value = v;
      b.last  = is_last;
      pending_beats.push_back(b);
   endtask

   task automatic queue_random_set(input int len, input value_mode_type mode);
      for (int i = 0; i < len; i++) push_beat(pick_value(mode), i == len - 1);
   endtask

   // No idling for a stretch in the middle of the run
   assign idle_pct = (accepted_beats >= 150 && accepted_beats < 260) ? 0 : 32;

   // Driver: hold a beat until taken, otherwise offer the next one or idle
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_beats[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predict on each taken beat, check each result beat
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("ascending_integer_sorter_core_tb NOT OK");
         $finish;
      end
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         beat_taken <= start && !busy;
         if (start && !busy) begin
            absorb_element(req_data);
            void'(pending_beats.pop_front());
            accepted_beats++;
         end
         if (rsp_strobe) begin
            if (expected_sorted.size() == 0) begin
               $error("unexpected result beat, sorted_value %0d", rsp_data.sorted_value);
               error_count++;
            end else begin
               want = expected_sorted.pop_front();
               if (rsp_data.sorted_value !== want.sorted_value) begin
                  $error("sorted_value expected %0d actual %0d",
                         want.sorted_value, rsp_data.sorted_value);
                  error_count++;
               end
               if (rsp_data.final_res !== want.final_res) begin
                  $error("final_res expected %0b actual %0b", want.final_res, rsp_data.final_res);
                  error_count++;
               end
               if (rsp_data.dropped !== want.dropped) begin
                  $error("dropped expected %0b actual %0b", want.dropped, rsp_data.dropped);
                  error_count++;
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int             random_beats;
      int             len;
      int             roll;
      value_mode_type mode;

      // single-element sets at both extremes
      push_beat(MostNegative, 1'b1);
      push_beat(MostPositive, 1'b1);
      // mixed extremes with repeats
      push_beat(MostPositive, 1'b0);
      push_beat(MostNegative, 1'b0);
      push_beat(0, 1'b0);
      push_beat(-1, 1'b0);
      push_beat(1, 1'b0);
      push_beat(MostNegative, 1'b0);
      push_beat(MostPositive, 1'b1);
      // all equal
      push_beat(5, 1'b0);
      push_beat(5, 1'b0);
      push_beat(5, 1'b1);
      // strictly descending arrival
      push_beat(3, 1'b0);
      push_beat(2, 1'b0);
      push_beat(1, 1'b1);

      // random sets: first an overflowing one, then an exactly full one
      random_beats = 0;
      queue_random_set(SetCapacity + 8, VAL_FULL);
      queue_random_set(SetCapacity, VAL_NARROW);
      random_beats = 2 * SetCapacity + 8;
      while (random_beats < RandomBeats) begin
         roll = $urandom_range(0, 99);
         if (roll < 60)      len = $urandom_range(1, 8);
         else if (roll < 85) len = $urandom_range(9, SetCapacity);
         else if (roll < 95) len = $urandom_range(SetCapacity - 1, SetCapacity + 1);
         else                len = $urandom_range(SetCapacity + 2, SetCapacity + 13);
         roll = $urandom_range(0, 9);
         mode = (roll < 6) ? VAL_FULL : (roll < 8) ? VAL_NARROW : VAL_EXTREME;
         queue_random_set(len, mode);
         random_beats += len;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      while (expected_sorted.size() != 0) @(posedge clock);
      repeat (DrainSlack) @(posedge clock);

      if (error_count == 0) begin
         $display("ascending_integer_sorter_core_tb OK");
      end else begin
         $display("ascending_integer_sorter_core_tb NOT OK");
      end
      $finish;
   end

endmodule
